@@ hdl/swpmm_pkg.sv @@
// ----------------------------------------------------------------------------
// swpmm_pkg
// Shared constants, operation and status codes, and cell control type for
// the fixed-depth stack with peek, minimum and maximum.
// ----------------------------------------------------------------------------
package swpmm_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;

  typedef enum logic [KIND_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_TOP   = 3'd2,
    OP_PEEK  = 3'd3,
    OP_MIN   = 3'd4,
    OP_MAX   = 3'd5,
    OP_CLEAR = 3'd6
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_BAD_PEEK = 2'd2,
    STAT_FULL     = 2'd3
  } stat_e;

  // push: every cell loads its upper neighbor, the top cell loads the operand
  // shift: every cell loads its lower neighbor, the bottom cell loads the top
  typedef struct packed {
    logic push;
    logic shift;
  } cell_ctl_t;

endpackage

@@ hdl/swpmm_if.sv @@
// ----------------------------------------------------------------------------
// swpmm_if
// Request and response channels of the stack: valid/ready handshake with
// the payload fields.
// ----------------------------------------------------------------------------
interface swpmm_req_if;
  logic                                valid;
  logic                                ready;
  logic [swpmm_pkg::KIND_W-1:0]        kind;
  logic signed [swpmm_pkg::DATA_W-1:0] operand;

  modport source (output valid, output kind, output operand, input ready);
  modport sink   (input valid, input kind, input operand, output ready);
endinterface

interface swpmm_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [swpmm_pkg::DATA_W-1:0] data;
  logic [swpmm_pkg::CNT_W-1:0]         count;
  logic                                is_empty;
  logic                                is_full;
  logic [swpmm_pkg::STAT_W-1:0]        status;

  modport source (output valid, output data, output count, output is_empty,
                  output is_full, output status, input ready);
  modport sink   (input valid, input data, input count, input is_empty,
                  input is_full, input status, output ready);
endinterface

@@ hdl/swpmm_cell.sv @@
// ----------------------------------------------------------------------------
// swpmm_cell
// One stack entry. Loads its upper neighbor on push, its lower neighbor on
// shift (pop or scan rotation), and holds otherwise.
// ----------------------------------------------------------------------------
module swpmm_cell (
  input  logic                                clk_i,
  input  swpmm_pkg::cell_ctl_t                ctl_i,
  input  logic signed [swpmm_pkg::DATA_W-1:0] above_i,
  input  logic signed [swpmm_pkg::DATA_W-1:0] below_i,
  output logic signed [swpmm_pkg::DATA_W-1:0] data_o
);
  import swpmm_pkg::*;

  logic signed [DATA_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      data_q <= above_i;
    end else if (ctl_i.shift) begin
      data_q <= below_i;
    end
  end

  assign data_o = data_q;

endmodule

@@ hdl/swpmm_ctrl.sv @@
// ----------------------------------------------------------------------------
// swpmm_ctrl
// Request decode, entry count, scan sequencer for peek/min/max over the
// rotating cell ring, and the response register.
// ----------------------------------------------------------------------------
module swpmm_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  swpmm_req_if.sink                           req_i,
  swpmm_rsp_if.source                         rsp_o,
  input  logic signed [swpmm_pkg::DATA_W-1:0] top_i,
  output swpmm_pkg::cell_ctl_t                ctl_o,
  output logic signed [swpmm_pkg::DATA_W-1:0] push_data_o
);
  import swpmm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [IDX_W-1:0]         k_q, k_d;
  logic [IDX_W-1:0]         tgt_q, tgt_d;
  op_e                      op_q, op_d;
  logic signed [DATA_W-1:0] acc_q, acc_d;

  logic                     res_valid_q, res_valid_d;
  logic signed [DATA_W-1:0] res_data_q, res_data_d;
  logic [CNT_W-1:0]         res_count_q;
  stat_e                    res_stat_q, res_stat_d;

  logic       in_ready;
  logic       accept;
  logic       load;
  logic       scan_last;
  logic       take;
  logic       better;
  logic       is_empty;
  logic       is_full;
  logic       peek_bad;
  op_e        kind;
  cell_ctl_t  ctl;

  assign in_ready    = (state_q == ST_IDLE) && (!res_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && in_ready;
  assign kind        = op_e'(req_i.kind);
  assign is_empty    = (count_q == '0);
  assign is_full     = (count_q == CNT_W'(DEPTH));
  assign peek_bad    = (req_i.operand == '0) ||
                       ($unsigned(req_i.operand) > {{(DATA_W-CNT_W){1'b0}}, count_q});
  assign scan_last   = (k_q == IDX_W'(DEPTH - 1));
  assign better      = (op_q == OP_MIN) ? (top_i < acc_q) : (top_i > acc_q);

  always_comb begin
    if (op_q == OP_PEEK) begin
      take = (k_q == tgt_q);
    end else begin
      take = (k_q == '0) || (({1'b0, k_q} < count_q) && better);
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    k_d        = k_q;
    tgt_d      = tgt_q;
    op_d       = op_q;
    acc_d      = acc_q;
    load       = 1'b0;
    res_data_d = '0;
    res_stat_d = STAT_OK;
    ctl        = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (kind)
            OP_PUSH: begin
              if (is_full) begin
                res_stat_d = STAT_FULL;
              end else begin
                ctl.push = 1'b1;
                count_d  = count_q + 1'b1;
              end
            end
            OP_POP: begin
              if (is_empty) begin
                res_stat_d = STAT_EMPTY;
              end else begin
                ctl.shift = 1'b1;
                count_d   = count_q - 1'b1;
              end
            end
            OP_TOP: begin
              if (is_empty) begin
                res_stat_d = STAT_EMPTY;
              end else begin
                res_data_d = top_i;
              end
            end
            OP_PEEK: begin
              if (peek_bad) begin
                res_stat_d = STAT_BAD_PEEK;
              end else begin
                load    = 1'b0;
                op_d    = OP_PEEK;
                tgt_d   = req_i.operand[IDX_W-1:0] - 1'b1;
                state_d = ST_SCAN;
              end
            end
            OP_MIN, OP_MAX: begin
              if (is_empty) begin
                res_stat_d = STAT_EMPTY;
              end else begin
                load    = 1'b0;
                op_d    = kind;
                state_d = ST_SCAN;
              end
            end
            OP_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        ctl.shift = 1'b1;
        acc_d     = take ? top_i : acc_q;
        if (scan_last) begin
          k_d        = '0;
          load       = 1'b1;
          res_data_d = acc_d;
          state_d    = ST_IDLE;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_valid_d = load | (res_valid_q & ~rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      k_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      k_q         <= k_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q <= tgt_d;
    op_q  <= op_d;
    acc_q <= acc_d;
    if (load) begin
      res_data_q  <= res_data_d;
      res_count_q <= count_d;
      res_stat_q  <= res_stat_d;
    end
  end

  assign ctl_o          = ctl;
  assign push_data_o    = req_i.operand;
  assign req_i.ready    = in_ready;
  assign rsp_o.valid    = res_valid_q;
  assign rsp_o.data     = res_data_q;
  assign rsp_o.count    = res_count_q;
  assign rsp_o.is_empty = (res_count_q == '0);
  assign rsp_o.is_full  = (res_count_q == CNT_W'(DEPTH));
  assign rsp_o.status   = res_stat_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!res_valid_q || rsp_o.ready))
    else $error("response overwritten before taken");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> (count_q == $past(count_q)))
    else $error("count changed without a request");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_stat_q != STAT_OK)) |-> (res_data_q == '0))
    else $error("error response carries data");

  a_scan_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (k_q == '0))
    else $error("scan counter not parked");

endmodule

@@ hdl/stack_with_peek_min_max_core.sv @@
// ----------------------------------------------------------------------------
// stack_with_peek_min_max_core
// Fixed-depth LIFO of signed words built as a ring of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request (kind, operand); rsp_o returns exactly one
//   response per request (data, count, is_empty, is_full, status), in order.
//   Cell 0 is the top of stack; push shifts the ring down, pop shifts it up.
//   Push, pop, top, clear and any request ending in an error respond in the
//   cycle after acceptance.
//   Peek, min and max rotate the whole ring once, one cell per cycle, while
//   watching cell 0, and respond once the rotation ends; the ring is back in
//   place when they finish.
//   A new request is taken while the controller is idle and the response
//   register is empty or being drained in the same cycle.
//   A stalled receiver holds the response register and blocks new requests.
//   Reset empties the stack (count zero) and drops any pending response;
//   the cell contents are not cleared and are only read below the count.
// ----------------------------------------------------------------------------
module stack_with_peek_min_max_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  swpmm_req_if.sink   req_i,
  swpmm_rsp_if.source rsp_o
);
  import swpmm_pkg::*;

  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] push_data;
  logic signed [DATA_W-1:0] cell_q [DEPTH];

  swpmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .top_i       (cell_q[0]),
    .ctl_o       (ctl),
    .push_data_o (push_data)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] above;
    logic signed [DATA_W-1:0] below;

    if (i == 0) begin : g_top
      assign above = push_data;
    end else begin : g_mid
      assign above = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_bot
      assign below = cell_q[0];
    end else begin : g_up
      assign below = cell_q[i+1];
    end

    swpmm_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .above_i (above),
      .below_i (below),
      .data_o  (cell_q[i])
    );
  end

endmodule
